/* hdl/nxtd_pkg.sv */
package nxtd_pkg;

	localparam int WIN_DEPTH = 32;
	localparam int TPL_COUNT = 8;

	localparam int SAMPLE_W = 12;
	localparam int COEF_W = 16;
	localparam int SCORE_W = 15;
	localparam int THR_W = 15;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [THR_W-1:0] THR_RESET = 15'd29491;

	// Word index of the threshold register on the configuration port.
	localparam logic CFG_IDX_THRESHOLD = 1'b0;

	localparam int ADDR_W = $clog2(WIN_DEPTH);
	localparam int LEN_W = $clog2(WIN_DEPTH + 1);
	localparam int TPL_W = (TPL_COUNT > 1) ? $clog2(TPL_COUNT) : 1;
	localparam int ROM_DEPTH = TPL_COUNT * WIN_DEPTH;
	localparam int ROM_AW = $clog2(ROM_DEPTH);

	localparam int SUM_W = SAMPLE_W + LEN_W;
	localparam int C_W = SUM_W + 1;
	localparam int SQ_W = 2 * SUM_W;
	localparam int PROD_W = C_W + COEF_W;
	localparam int DOT_W = PROD_W + LEN_W;
	localparam int E_W = SQ_W + LEN_W;
	localparam int RAD_W = E_W + 20 + (E_W % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int NUM_W = DOT_W + 9;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef coef_t tpl_rom_t [ROM_DEPTH];
	typedef len_t tpl_len_arr_t [TPL_COUNT];

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_DOT,
		ST_CHECK,
		ST_SQRT,
		ST_DIV,
		ST_NEXT,
		ST_OUT
	} state_t;

	localparam int RAW_COUNT = 8;
	localparam int RAW_TOTAL = 171;

	localparam int RAW_LEN [RAW_COUNT] = '{16, 24, 18, 19, 23, 24, 26, 21};

	// Raw template taps in units of 1e-4.
	localparam int RAW_TAPS [RAW_TOTAL] = '{
		2275280, 2258890, 2193890, 1847780, 1446110, 1383330, 1729440, 2229170, 1860280,
		1433060, 1296940, 1735830, 2130830, 2226670, 2282780, 2329170,
		2388060, 2367220, 2352500, 2113330, 1413890, 1164170, 1512220, 2140280, 2390280,
		2344720, 1745560, 950000, 1220280, 1798610, 1973610, 2098060, 2146670, 2205830,
		2271940, 2294170, 2345000, 2371940, 2404720, 2425830,
		2508060, 2503610, 2451390, 2149440, 1321670, 1004170, 1587220, 2190830, 1983060,
		1066940, 1031940, 1494720, 1961940, 2195280, 2376110, 2515000, 2550000, 2550000,
		1977220, 2021390, 2071670, 1967220, 1580560, 812778, 883056, 1566110, 1843610,
		1547220, 841389, 591944, 923056, 1643060, 1958060, 2124170, 2231670, 2311390,
		2308890,
		1944440, 1989440, 2048890, 2076390, 1948610, 1450280, 908889, 966389, 1675830,
		2033330, 1810280, 831944, 803333, 1278060, 1548330, 1670560, 1801390, 1883060,
		1963330, 2121940, 2174440, 2211110, 2282500,
		1276110, 1270830, 1258890, 1264440, 1260000, 1233890, 1155280, 870000, 838889,
		1068060, 1275560, 1211390, 914444, 606111, 907778, 1102500, 1204720, 1223060,
		1245280, 1260560, 1257500, 1276670, 1293330, 1293330,
		1481110, 1495000, 1531390, 1570560, 1704720, 1778610, 1857500, 1936110, 1978890,
		1968890, 1824170, 1408890, 902500, 951944, 1381940, 1643890, 1948610, 2066110,
		2136390, 2108610, 1955000, 1536110, 1483890, 1624440, 1712220, 1739440,
		1749170, 1817220, 1892500, 1575280, 1061670, 1417500, 1563890, 1222500, 1196670,
		1421940, 1592500, 1661110, 1705000, 1739440, 1776940, 1793890, 1792500, 1792220,
		1789170, 1780560, 1773890
	};

	function automatic longint unsigned isqrt64(longint unsigned n);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned bitv;
		rem = n;
		res = 0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Shift-and-subtract quotient, used only while the tables are built.
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		logic [64:0] rem;
		quo = 0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic tpl_rom_t build_tpl_rom();
		tpl_rom_t rom;
		int start;
		int len;
		int first;
		longint sum;
		longint d;
		longint unsigned energy;
		longint unsigned nrm;
		longint unsigned mag;
		longint unsigned q;
		coef_t qc;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			rom[i] = '0;
		end
		start = 0;
		for (int t = 0; t < RAW_COUNT; t++) begin
			if (t < TPL_COUNT) begin
				len = (RAW_LEN[t] > WIN_DEPTH) ? WIN_DEPTH : RAW_LEN[t];
				first = start + RAW_LEN[t] - len;
				sum = 0;
				energy = 0;
				for (int i = 0; i < len; i++) begin
					sum = sum + RAW_TAPS[first + i];
				end
				for (int i = 0; i < len; i++) begin
					d = longint'(len) * RAW_TAPS[first + i] - sum;
					energy = energy + longint'(d * d);
				end
				nrm = isqrt64(energy);
				for (int i = 0; i < len; i++) begin
					d = longint'(len) * RAW_TAPS[first + i] - sum;
					mag = (d < 0) ? longint'(-d) : longint'(d);
					q = 0;
					if (nrm != 0) begin
						q = udiv64(mag * 32768 + (nrm >> 1), nrm);
					end
					if (q > 32767) begin
						q = 32767;
					end
					qc = coef_t'(q[COEF_W-1:0]);
					rom[t * WIN_DEPTH + i] = (d < 0) ? -qc : qc;
				end
			end
			start = start + RAW_LEN[t];
		end
		return rom;
	endfunction

	function automatic tpl_len_arr_t build_tpl_len();
		tpl_len_arr_t lens;
		for (int t = 0; t < TPL_COUNT; t++) begin
			if (t < RAW_COUNT) begin
				lens[t] = len_t'((RAW_LEN[t] > WIN_DEPTH) ? WIN_DEPTH : RAW_LEN[t]);
			end else begin
				lens[t] = '0;
			end
		end
		return lens;
	endfunction

	localparam tpl_rom_t TPL_ROM = build_tpl_rom();
	localparam tpl_len_arr_t TPL_LEN = build_tpl_len();

endpackage

/* hdl/nxtd_sample_if.sv */
interface nxtd_sample_if;
	import nxtd_pkg::*;

	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* hdl/nxtd_result_if.sv */
interface nxtd_result_if;
	import nxtd_pkg::*;

	logic valid;
	logic ready;
	logic [SCORE_W-1:0] score;
	logic detected;

	modport source (output valid, output score, output detected, input ready);
	modport sink (input valid, input score, input detected, output ready);
endinterface

/* hdl/nxtd_window_mem.sv */
module nxtd_window_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [nxtd_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [nxtd_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [nxtd_pkg::ADDR_W-1:0]   rd_addr,
	output logic [nxtd_pkg::SAMPLE_W-1:0] rd_data
);
	import nxtd_pkg::*;

	logic [SAMPLE_W-1:0] mem [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] written_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_q : '0;
endmodule

/* hdl/nxtd_isqrt.sv */
module nxtd_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nxtd_pkg::RAD_W-1:0]  radicand,
	output logic [nxtd_pkg::ROOT_W-1:0] root,
	output nxtd_pkg::unit_stat_t        stat
);
	import nxtd_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [RAD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One result bit per cycle, two radicand bits consumed per step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign stat = '{busy: busy_q, done: done_q};
endmodule

/* hdl/nxtd_div.sv */
module nxtd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nxtd_pkg::NUM_W-1:0]   num,
	input  logic [nxtd_pkg::ROOT_W-1:0]  den,
	output logic [nxtd_pkg::SCORE_W-1:0] quot,
	output nxtd_pkg::unit_stat_t         stat
);
	import nxtd_pkg::*;

	localparam int DW = (NUM_W > ROOT_W + SCORE_W) ? NUM_W : ROOT_W + SCORE_W;
	localparam int CNT_W = $clog2(SCORE_W);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [SCORE_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW-1:0] num_x;
	logic [DW-1:0] den_x;
	logic sat;

	assign num_x = DW'(num);
	assign den_x = DW'(den);
	// A quotient that would not fit in the score saturates right away.
	assign sat = num_x >= (den_x << SCORE_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q <= CNT_W'(SCORE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_x;
			dsh_q <= den_x << (SCORE_W - 1);
			quot_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quot_q <= {quot_q[SCORE_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[SCORE_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quot = quot_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

/* hdl/normalized_xcorr_template_detector.sv */
// Normalized cross-correlation template detector.
// samples: one 12-bit unsigned Q8.4 brightness value per beat. scores: one beat per
// sample with the best template correlation (Q0.15, floored at zero, saturated) and
// a detected flag set when that score is at least the threshold register.
// Threshold is written over the APB port at byte address 0 (reset value 29491).
// Each sample enters a 32-entry circular window memory. For every template the
// sequencer sweeps the window twice through the memory's single read port: once
// for the window sum, once for energy and dot product. A non-flat, positively
// correlated template then runs a square root and a divide; a quotient that
// saturates ends the divide early. One sample is processed at a time: samples.ready
// is high only while the sequencer is idle.
// The score sits in an output register; a stalled receiver does not stop the next
// sample from being accepted, but that sample's score waits until the previous
// one has been taken. Reset clears the window to zero, empties the output and
// restores the threshold.
module normalized_xcorr_template_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	nxtd_sample_if.sink                 samples,
	nxtd_result_if.source               scores,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nxtd_pkg::CFG_AW-1:0] paddr,
	input  logic [nxtd_pkg::CFG_DW-1:0] pwdata,
	output logic [nxtd_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import nxtd_pkg::*;

	state_t state_q, state_d;

	logic [THR_W-1:0] thr_q;
	logic [ADDR_W-1:0] head_q;
	logic [TPL_W-1:0] t_q;
	len_t len_q;
	len_t j_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] start_addr_q;
	logic [ROM_AW-1:0] rom_base_q;
	logic vld_s1, vld_s2, vld_s3;
	len_t j_s1;
	logic out_valid_q;
	logic [SCORE_W-1:0] best_q;

	logic [SUM_W-1:0] sum_q;
	logic [E_W-1:0] energy_q;
	logic signed [DOT_W-1:0] dot_q;
	logic signed [C_W-1:0] c_s2;
	coef_t q_s2;
	logic [SQ_W-1:0] sq_s3;
	logic signed [PROD_W-1:0] pr_s3;
	logic [SCORE_W-1:0] score_q;
	logic detected_q;

	logic accept;
	logic cfg_wr;
	logic issue;
	logic pass_done;
	logic rewind;
	logic load_out;
	logic sq_start;
	logic div_start;
	logic last_tpl;
	len_t cur_len;
	logic [ADDR_W:0] start_sum;
	logic [ADDR_W:0] start_wrap;
	logic [ADDR_W-1:0] addr_next;
	logic [SAMPLE_W-1:0] win_rd;
	logic [SUM_W-1:0] lw;
	logic signed [C_W-1:0] c_next;
	logic signed [2*C_W-1:0] sq_full;
	logic [ROOT_W-1:0] root;
	logic [SCORE_W-1:0] quot;
	unit_stat_t sq_stat;
	unit_stat_t div_stat;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == CFG_IDX_THRESHOLD) ? CFG_DW'(thr_q) : '0;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);

	assign cur_len = TPL_LEN[t_q];
	assign last_tpl = (t_q == TPL_W'(TPL_COUNT - 1));
	assign issue = ((state_q == ST_SUM) || (state_q == ST_DOT)) && (j_q != len_q);
	assign pass_done = (j_q == len_q) && !vld_s1 && !vld_s2 && !vld_s3;

	// Oldest of the newest L samples sits L entries behind the write pointer.
	assign start_sum = {1'b0, head_q} + (ADDR_W + 1)'(WIN_DEPTH) - (ADDR_W + 1)'(cur_len);
	assign start_wrap = (start_sum >= (ADDR_W + 1)'(WIN_DEPTH)) ?
		start_sum - (ADDR_W + 1)'(WIN_DEPTH) : start_sum;
	assign addr_next = (addr_q == ADDR_W'(WIN_DEPTH - 1)) ? '0 : addr_q + 1'b1;

	nxtd_window_mem u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_addr (head_q),
		.wr_data (samples.sample),
		.rd_addr (addr_q),
		.rd_data (win_rd)
	);

	nxtd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (RAD_W'({energy_q, 20'b0})),
		.root     (root),
		.stat     (sq_stat)
	);

	nxtd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NUM_W'({dot_q[DOT_W-2:0], 10'b0})),
		.den    (root),
		.quot   (quot),
		.stat   (div_stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = (cur_len == '0) ? ST_NEXT : ST_SUM;
			end
			ST_SUM: begin
				if (pass_done) begin
					state_d = ST_DOT;
				end
			end
			ST_DOT: begin
				if (pass_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ((energy_q == '0) || (dot_q <= 0)) ? ST_NEXT : ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_stat.done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_d = last_tpl ? ST_OUT : ST_LOAD;
			end
			ST_OUT: begin
				if (!out_valid_q || scores.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rewind = (state_q == ST_SUM) && pass_done;
		sq_start = (state_q == ST_CHECK) && (energy_q != '0) && (dot_q > 0);
		div_start = (state_q == ST_SQRT) && sq_stat.done;
		load_out = (state_q == ST_OUT) && (!out_valid_q || scores.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= THR_RESET;
			head_q <= '0;
			t_q <= '0;
			len_q <= '0;
			j_q <= '0;
			addr_q <= '0;
			start_addr_q <= '0;
			rom_base_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			best_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && (paddr[2] == CFG_IDX_THRESHOLD)) begin
				thr_q <= pwdata[THR_W-1:0];
			end
			if (accept) begin
				head_q <= (head_q == ADDR_W'(WIN_DEPTH - 1)) ? '0 : head_q + 1'b1;
				t_q <= '0;
				best_q <= '0;
				rom_base_q <= '0;
			end
			if (state_q == ST_LOAD) begin
				len_q <= cur_len;
				j_q <= '0;
				addr_q <= start_wrap[ADDR_W-1:0];
				start_addr_q <= start_wrap[ADDR_W-1:0];
			end else if (rewind) begin
				j_q <= '0;
				addr_q <= start_addr_q;
			end else if (issue) begin
				j_q <= j_q + 1'b1;
				addr_q <= addr_next;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && (state_q == ST_DOT);
			vld_s3 <= vld_s2;
			if (div_stat.done && (quot > best_q)) begin
				best_q <= quot;
			end
			if ((state_q == ST_NEXT) && !last_tpl) begin
				t_q <= t_q + 1'b1;
				rom_base_q <= rom_base_q + ROM_AW'(WIN_DEPTH);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (scores.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Centering needs the full window sum, so the second sweep forms c = L*w - sum.
	assign lw = SUM_W'(len_q) * SUM_W'(win_rd);
	assign c_next = signed'({1'b0, lw}) - signed'({1'b0, sum_q});
	assign sq_full = c_s2 * c_s2;

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		c_s2 <= c_next;
		q_s2 <= TPL_ROM[rom_base_q + ROM_AW'(j_s1)];
		sq_s3 <= sq_full[SQ_W-1:0];
		pr_s3 <= c_s2 * q_s2;
		if (state_q == ST_LOAD) begin
			sum_q <= '0;
			energy_q <= '0;
			dot_q <= '0;
		end else begin
			if ((state_q == ST_SUM) && vld_s1) begin
				sum_q <= sum_q + SUM_W'(win_rd);
			end
			if (vld_s3) begin
				energy_q <= energy_q + E_W'(sq_s3);
				dot_q <= dot_q + DOT_W'(pr_s3);
			end
		end
		if (load_out) begin
			score_q <= best_q;
			detected_q <= (best_q >= thr_q);
		end
	end

	assign scores.valid = out_valid_q;
	assign scores.score = score_q;
	assign scores.detected = detected_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD))
		else $error("accepted sample did not start the template sweep");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !sq_stat.busy)
		else $error("square root still busy during divide");

	a_products_in_dot: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (state_q == ST_DOT))
		else $error("product beat outside the dot-product sweep");

	a_out_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> $past(state_q == ST_NEXT) || $past(state_q == ST_OUT))
		else $error("score loaded before all templates were visited");
`endif
endmodule
